@@ rtl/opl_pkg.sv @@
package opl_pkg;

  localparam int MAX_TRACKS_DEF = 99;
  localparam int TRACK_W        = 7;
  localparam int CMD_W          = 3;
  localparam int STAT_W         = 3;

  localparam logic [TRACK_W-1:0] LIMIT_RESET = 7'd99;

  // commands
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REWIND  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_RANGE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP    = 3'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd5;
  localparam logic [STAT_W-1:0] ST_PAST   = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [TRACK_W-1:0] track;
  } opl_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               present;
    logic [TRACK_W-1:0] selection_count;
    logic [TRACK_W-1:0] cursor_pos;
    logic               finished;
    logic [TRACK_W-1:0] track_out;
    logic               next_valid;
    logic [TRACK_W-1:0] first_track;
    logic [TRACK_W-1:0] last_track;
  } opl_out_t;

endpackage

@@ rtl/ordered_unique_playlist_core.sv @@
// Channel   Direction  Handshake                 Payload
// in_       input      in_valid / in_stall       opl_in_t  (command, track)
// out_      output     out_valid / out_stall     opl_out_t (status ... last_track)
// cfg_      input      cfg_wr_en                 track_limit (7 bits)
//
// One command at a time; a word runs from accept to the next accept through the
// scan, the execute step, the compaction of a remove, reads of the first, last and
// next entries and the result load. The scan stops at the match and a remove
// compacts only the entries behind it. Synchronous reset (rst_n low) empties the
// list, parks the cursor and sets track_limit to 99; the list RAM is not cleared.
// A new command is taken while the previous result waits under out_stall.
module ordered_unique_playlist_core #(
  parameter int MAX_TRACKS = opl_pkg::MAX_TRACKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  opl_pkg::opl_in_t                in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output opl_pkg::opl_out_t               out_word,
  input  logic                            cfg_wr_en,
  input  logic [opl_pkg::TRACK_W-1:0]     cfg_wr_data
);

  import opl_pkg::*;

  localparam int ADDR_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TRACKS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_FIN0  = 4'd4;
  localparam logic [3:0] S_FIN1  = 4'd5;
  localparam logic [3:0] S_FIN2  = 4'd6;
  localparam logic [3:0] S_FIN3  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]         state_r,   state_nxt;
  logic [CMD_W-1:0]   cmd_r,     cmd_nxt;
  logic [TRACK_W-1:0] trk_r,     trk_nxt;
  logic               inrng_r,   inrng_nxt;
  logic [CNT_W-1:0]   scan_r,    scan_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [CNT_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic               found_r,   found_nxt;
  logic [CNT_W-1:0]   pos_r,     pos_nxt;
  logic [CNT_W-1:0]   count_r,   count_nxt;
  logic [CNT_W-1:0]   cursor_r,  cursor_nxt;
  logic [STAT_W-1:0]  status_r,  status_nxt;
  logic               present_r, present_nxt;
  logic               adv_r,     adv_nxt;
  logic [TRACK_W-1:0] first_r,   first_nxt;
  logic [TRACK_W-1:0] last_r,    last_nxt;
  logic [TRACK_W-1:0] tout_r,    tout_nxt;
  logic [TRACK_W-1:0] limit_r;
  logic               out_valid_r;
  opl_out_t           out_word_r;

  // list RAM ports
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [TRACK_W-1:0] ram_wdata, ram_rdata;

  logic               in_acc, out_load, ram_hit, scan_last;
  logic [CNT_W-1:0]   cnt_dec, last_idx, tout_idx, chk_prev;
  logic               tout_ok;
  opl_out_t           result;

  opl_ram #(
    .WIDTH (TRACK_W),
    .DEPTH (MAX_TRACKS)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign cnt_dec   = count_r - CNT_W'(1);
  assign last_idx  = cnt_dec;
  assign chk_prev  = chk_idx_r - CNT_W'(1);
  assign ram_hit   = chk_vld_r && (ram_rdata == trk_r);
  assign scan_last = chk_vld_r && (chk_idx_r == cnt_dec);
  // after an advance the new current entry sits one behind the cursor
  assign tout_ok   = adv_r || (cursor_r < count_r);
  assign tout_idx  = adv_r ? (cursor_r - CNT_W'(1)) : cursor_r;

  // RAM port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[ADDR_W-1:0];
    ram_wdata = trk_r;
    ram_re    = 1'b0;
    ram_raddr = scan_r[ADDR_W-1:0];
    unique case (state_r)
      S_SRCH: begin
        ram_re = (scan_r < count_r);
      end
      S_EXEC: begin
        // append lands at the tail
        ram_we = (cmd_r == CMD_APPEND) && inrng_r && !found_r &&
                 (count_r < CNT_W'(MAX_TRACKS));
      end
      S_SHIFT: begin
        ram_re    = (scan_r < count_r);
        ram_we    = chk_vld_r;
        ram_waddr = chk_prev[ADDR_W-1:0];
        ram_wdata = ram_rdata;
      end
      S_FIN0: begin
        ram_re    = (count_r != '0);
        ram_raddr = '0;
      end
      S_FIN1: begin
        ram_re    = (count_r != '0);
        ram_raddr = last_idx[ADDR_W-1:0];
      end
      S_FIN2: begin
        ram_re    = tout_ok;
        ram_raddr = tout_idx[ADDR_W-1:0];
      end
      S_IDLE, S_FIN3, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // command sequencer
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    trk_nxt     = trk_r;
    inrng_nxt   = inrng_r;
    scan_nxt    = scan_r;
    chk_vld_nxt = chk_vld_r;
    chk_idx_nxt = chk_idx_r;
    found_nxt   = found_r;
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    cursor_nxt  = cursor_r;
    status_nxt  = status_r;
    present_nxt = present_r;
    adv_nxt     = adv_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    tout_nxt    = tout_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt     = in_word.command;
          trk_nxt     = in_word.track;
          inrng_nxt   = (in_word.track < limit_r);
          scan_nxt    = '0;
          chk_vld_nxt = 1'b0;
          found_nxt   = 1'b0;
          status_nxt  = ST_OK;
          adv_nxt     = 1'b0;
          // skip the scan when nothing can match
          state_nxt   = ((in_word.track < limit_r) && (count_r != '0)) ? S_SRCH : S_EXEC;
        end
      end
      S_SRCH: begin
        // issue one read a cycle, compare the word returned from the last one
        if (scan_r < count_r) begin
          scan_nxt = scan_r + CNT_W'(1);
        end
        chk_vld_nxt = (scan_r < count_r);
        chk_idx_nxt = scan_r;
        if (ram_hit) begin
          found_nxt = 1'b1;
          pos_nxt   = chk_idx_r;
          state_nxt = S_EXEC;
        end else if (scan_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        chk_vld_nxt = 1'b0;
        present_nxt = found_r;
        state_nxt   = S_FIN0;
        case (cmd_r)
          CMD_APPEND: begin
            if (!inrng_r) begin
              status_nxt = ST_RANGE;
            end else if (found_r) begin
              status_nxt = ST_DUP;
            end else if (count_r >= CNT_W'(MAX_TRACKS)) begin
              status_nxt = ST_FULL;
            end else begin
              count_nxt   = count_r + CNT_W'(1);
              present_nxt = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (!inrng_r) begin
              status_nxt = ST_RANGE;
            end else if (!found_r) begin
              status_nxt = ST_ABSENT;
            end else begin
              present_nxt = 1'b0;
              if ((pos_r + CNT_W'(1)) < count_r) begin
                scan_nxt  = pos_r + CNT_W'(1);
                state_nxt = S_SHIFT;
              end else begin
                count_nxt = cnt_dec;
                if (cursor_r > cnt_dec) begin
                  cursor_nxt = cnt_dec;
                end
              end
            end
          end
          CMD_ADVANCE: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (cursor_r >= count_r) begin
              status_nxt = ST_PAST;
            end else begin
              cursor_nxt = cursor_r + CNT_W'(1);
              adv_nxt    = 1'b1;
            end
          end
          CMD_REWIND: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              cursor_nxt = CNT_W'(1);
            end
          end
          default: begin
            // unknown commands act as a query but never flag the range
            if ((cmd_r == CMD_QUERY) && !inrng_r) begin
              status_nxt = ST_RANGE;
            end
          end
        endcase
      end
      S_SHIFT: begin
        // read entry k+1 ahead, write it back to k in the next cycle
        if (scan_r < count_r) begin
          scan_nxt = scan_r + CNT_W'(1);
        end
        chk_vld_nxt = (scan_r < count_r);
        chk_idx_nxt = scan_r;
        if (scan_last) begin
          chk_vld_nxt = 1'b0;
          count_nxt   = cnt_dec;
          if (cursor_r > cnt_dec) begin
            cursor_nxt = cnt_dec;
          end
          state_nxt = S_FIN0;
        end
      end
      S_FIN0: begin
        state_nxt = S_FIN1;
      end
      S_FIN1: begin
        first_nxt = ram_rdata;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        last_nxt  = ram_rdata;
        state_nxt = S_FIN3;
      end
      S_FIN3: begin
        tout_nxt  = ram_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result word
  always_comb begin
    result.status          = status_r;
    result.present         = present_r;
    result.selection_count = TRACK_W'(count_r);
    result.cursor_pos      = TRACK_W'(cursor_r);
    result.finished        = (count_r != '0) && (cursor_r == count_r);
    result.track_out       = tout_ok ? tout_r : '0;
    result.next_valid      = tout_ok;
    result.first_track     = (count_r != '0) ? first_r : '0;
    result.last_track      = (count_r != '0) ? last_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      chk_vld_r   <= 1'b0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cursor_r  <= cursor_nxt;
      chk_vld_r <= chk_vld_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      // hold the result until taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    trk_r     <= trk_nxt;
    inrng_r   <= inrng_nxt;
    scan_r    <= scan_nxt;
    chk_idx_r <= chk_idx_nxt;
    found_r   <= found_nxt;
    pos_r     <= pos_nxt;
    status_r  <= status_nxt;
    present_r <= present_nxt;
    adv_r     <= adv_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    tout_r    <= tout_nxt;
    if (out_load) begin
      out_word_r <= result;
    end
  end

endmodule

@@ rtl/opl_ram.sv @@
module opl_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 99
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/opl_checker.sv @@
module opl_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  opl_pkg::opl_out_t           out_word
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result changed under stall");

  // one command in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while busy");

  a_finished_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.finished |->
      (out_word.cursor_pos == out_word.selection_count) &&
      (out_word.selection_count != '0))
    else $error("finished without cursor on last entry");

  a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.selection_count == '0) |->
      !out_word.present && !out_word.next_valid && (out_word.cursor_pos == '0))
    else $error("empty list reports an entry");

endmodule

bind ordered_unique_playlist_core opl_checker u_opl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_word    (out_word)
);
